// File: design/i2cmw_pkg.sv
// Shared types and codes for the write-only I2C master engine.
// No dependencies; used by i2cmw_engine and i2c_master_write_engine_top.
`timescale 1ns / 1ps

package i2cmw_pkg;

   localparam int PHASE_W = 4;

   localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
   localparam logic [PHASE_W-1:0] PH_START_A   = 4'd1;
   localparam logic [PHASE_W-1:0] PH_START_B   = 4'd2;
   localparam logic [PHASE_W-1:0] PH_START_C   = 4'd3;
   localparam logic [PHASE_W-1:0] PH_BIT_LOW   = 4'd4;
   localparam logic [PHASE_W-1:0] PH_BIT_HIGH  = 4'd5;
   localparam logic [PHASE_W-1:0] PH_ACK_LOW   = 4'd6;
   localparam logic [PHASE_W-1:0] PH_ACK_HIGH  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_ACK_TAIL  = 4'd8;
   localparam logic [PHASE_W-1:0] PH_WAIT_DATA = 4'd9;
   localparam logic [PHASE_W-1:0] PH_STOP_A    = 4'd10;
   localparam logic [PHASE_W-1:0] PH_STOP_B    = 4'd11;
   localparam logic [PHASE_W-1:0] PH_STOP_C    = 4'd12;

   localparam logic [1:0] CMD_BEGIN = 2'd1;
   localparam logic [1:0] CMD_DATA  = 2'd2;

   localparam logic [3:0] BYTE_BITS = 4'd8;

   localparam logic [7:0] HALF_PERIOD_RESET = 8'd3;

   localparam int          ADDR_W          = 3;
   localparam logic [0:0]  REG_HALF_PERIOD = 1'b0;

   typedef struct packed {
      logic [1:0] command;
      logic [6:0] address;
      logic [7:0] data_byte;
      logic       last;
      logic       tick;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic scl_pull_low;
      logic sda_pull_low;
      logic ready_res;
      logic done_res;
      logic acked_ok;
   } result_type;

endpackage

// File: design/i2c_master_write_engine_top.sv
// Requests are registered in the input register, results in the result register;
// one request per cycle unless rsp_stall blocks; the sequencer steps once per request.
// The input register doubles as a skid stage, so one request is taken while
// a result waits on a stalled rsp_ side.
// Reset (synchronous, active high) returns the bus to idle with both lines
// released, empties both stages and sets the half period to 3 ticks.
`timescale 1ns / 1ps

module i2c_master_write_engine_top (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic [6:0]                    req_address,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last,
   input  logic                          req_tick,
   input  logic                          req_sda_in,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_scl_pull_low,
   output logic                          rsp_sda_pull_low,
   output logic                          rsp_ready_res,
   output logic                          rsp_done_res,
   output logic                          rsp_acked_ok,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [i2cmw_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   // ---------------------------------------------------------------------
   // Register file: a single half period register at byte address 0.
   // ---------------------------------------------------------------------
   logic [7:0] half_period_ff;
   logic       reg_sel_half;
   logic       reg_write;

   assign pready       = 1'b1;
   assign reg_sel_half = paddr[i2cmw_pkg::ADDR_W-1:2] == i2cmw_pkg::REG_HALF_PERIOD;
   assign reg_write    = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= i2cmw_pkg::HALF_PERIOD_RESET;
      end else if (reg_write && reg_sel_half) begin
         half_period_ff <= pwdata[7:0];
      end
   end

   // Reads of unmapped addresses return zero.
   assign prdata = reg_sel_half ? {24'd0, half_period_ff} : 32'd0;

   // ---------------------------------------------------------------------
   // Input register. It holds the request while the result stage is
   // blocked, so it also serves as the skid slot.
   // ---------------------------------------------------------------------
   logic                  in_valid_ff;
   i2cmw_pkg::item_type   in_item_ff;
   logic                  req_take;
   logic                  rsp_block;
   logic                  step;
   logic                  rsp_valid_ff;

   // The result register is blocked only while it holds a result that
   // the far side is stalling.
   assign rsp_block = rsp_valid_ff & rsp_stall;
   assign step      = in_valid_ff & ~rsp_block;
   assign req_stall = in_valid_ff & rsp_block;
   assign req_take  = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Payload needs no reset; capture only on a taken request.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.command   <= req_command;
         in_item_ff.address   <= req_address;
         in_item_ff.data_byte <= req_data_byte;
         in_item_ff.last      <= req_last;
         in_item_ff.tick      <= req_tick;
         in_item_ff.sda_in    <= req_sda_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: advance the bus phase by one request when it moves on.
   // ---------------------------------------------------------------------
   i2cmw_pkg::result_type step_result;

   i2cmw_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (in_item_ff),
      .half_period (half_period_ff),
      .result      (step_result)
   );

   // ---------------------------------------------------------------------
   // Result register: load on every step, drop valid once taken.
   // ---------------------------------------------------------------------
   i2cmw_pkg::result_type  rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_pull_low = rsp_data_ff.scl_pull_low;
   assign rsp_sda_pull_low = rsp_data_ff.sda_pull_low;
   assign rsp_ready_res    = rsp_data_ff.ready_res;
   assign rsp_done_res     = rsp_data_ff.done_res;
   assign rsp_acked_ok     = rsp_data_ff.acked_ok;

endmodule

// File: design/i2cmw_engine.sv
// Bus phase sequencer of the write-only I2C master: state registers and
// one-step next-state logic. Depends on i2cmw_pkg.
`timescale 1ns / 1ps

module i2cmw_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  i2cmw_pkg::item_type    item,
   input  logic [7:0]             half_period,
   output i2cmw_pkg::result_type  result
);

   logic [i2cmw_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [7:0] half_counter_ff, half_counter_in;
   logic [3:0] bit_counter_ff, bit_counter_in;
   logic [7:0] shift_ff, shift_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       stop_ff, stop_in;
   logic       ack_ff, ack_in;
   logic       done;
   logic       ok;
   logic [8:0] count_next;
   logic       elapsed;
   logic [3:0] bit_count_inc;

   assign count_next    = {1'b0, half_counter_ff} + 9'd1;
   assign elapsed       = count_next >= {1'b0, half_period};
   assign bit_count_inc = bit_counter_ff + 4'd1;

   always_comb begin
      phase_in        = phase_ff;
      half_counter_in = half_counter_ff;
      bit_counter_in  = bit_counter_ff;
      shift_in        = shift_ff;
      scl_in          = scl_ff;
      sda_in          = sda_ff;
      stop_in         = stop_ff;
      ack_in          = ack_ff;
      done            = 1'b0;
      ok              = 1'b0;
      if (phase_ff == i2cmw_pkg::PH_IDLE) begin
         if (item.command == i2cmw_pkg::CMD_BEGIN) begin
            shift_in        = {item.address, 1'b0};
            stop_in         = item.last;
            ack_in          = 1'b1;
            sda_in          = 1'b0;
            scl_in          = 1'b0;
            half_counter_in = 8'd0;
            phase_in        = i2cmw_pkg::PH_START_A;
         end
      end else if (phase_ff == i2cmw_pkg::PH_WAIT_DATA) begin
         if (item.command == i2cmw_pkg::CMD_DATA) begin
            // load the byte and put its MSB on the bus
            stop_in         = item.last;
            bit_counter_in  = 4'd0;
            sda_in          = ~item.data_byte[7];
            shift_in        = {item.data_byte[6:0], 1'b0};
            half_counter_in = 8'd0;
            phase_in        = i2cmw_pkg::PH_BIT_LOW;
         end
      end else if (item.tick) begin
         half_counter_in = elapsed ? 8'd0 : count_next[7:0];
         if (elapsed) begin
            case (phase_ff)
               i2cmw_pkg::PH_START_A: begin
                  sda_in   = 1'b1;
                  phase_in = i2cmw_pkg::PH_START_B;
               end
               i2cmw_pkg::PH_START_B: begin
                  scl_in   = 1'b1;
                  phase_in = i2cmw_pkg::PH_START_C;
               end
               i2cmw_pkg::PH_START_C: begin
                  bit_counter_in = 4'd0;
                  sda_in         = ~shift_ff[7];
                  shift_in       = {shift_ff[6:0], 1'b0};
                  phase_in       = i2cmw_pkg::PH_BIT_LOW;
               end
               i2cmw_pkg::PH_BIT_LOW: begin
                  scl_in   = 1'b0;
                  phase_in = i2cmw_pkg::PH_BIT_HIGH;
               end
               i2cmw_pkg::PH_BIT_HIGH: begin
                  scl_in         = 1'b1;
                  bit_counter_in = bit_count_inc;
                  if (bit_count_inc < i2cmw_pkg::BYTE_BITS) begin
                     sda_in   = ~shift_ff[7];
                     shift_in = {shift_ff[6:0], 1'b0};
                     phase_in = i2cmw_pkg::PH_BIT_LOW;
                  end else begin
                     sda_in   = 1'b0;
                     phase_in = i2cmw_pkg::PH_ACK_LOW;
                  end
               end
               i2cmw_pkg::PH_ACK_LOW: begin
                  scl_in   = 1'b0;
                  phase_in = i2cmw_pkg::PH_ACK_HIGH;
               end
               i2cmw_pkg::PH_ACK_HIGH: begin
                  ack_in   = ~item.sda_in;
                  scl_in   = 1'b1;
                  phase_in = i2cmw_pkg::PH_ACK_TAIL;
               end
               i2cmw_pkg::PH_ACK_TAIL: begin
                  if (!ack_ff || stop_ff) begin
                     sda_in   = 1'b1;
                     phase_in = i2cmw_pkg::PH_STOP_A;
                  end else begin
                     phase_in = i2cmw_pkg::PH_WAIT_DATA;
                  end
               end
               i2cmw_pkg::PH_STOP_A: begin
                  scl_in   = 1'b0;
                  phase_in = i2cmw_pkg::PH_STOP_B;
               end
               i2cmw_pkg::PH_STOP_B: begin
                  sda_in   = 1'b0;
                  phase_in = i2cmw_pkg::PH_STOP_C;
               end
               i2cmw_pkg::PH_STOP_C: begin
                  done     = 1'b1;
                  ok       = ack_ff;
                  phase_in = i2cmw_pkg::PH_IDLE;
               end
               default: begin
                  phase_in = i2cmw_pkg::PH_IDLE;
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= i2cmw_pkg::PH_IDLE;
         half_counter_ff <= 8'd0;
         bit_counter_ff  <= 4'd0;
         shift_ff        <= 8'd0;
         scl_ff          <= 1'b0;
         sda_ff          <= 1'b0;
         stop_ff         <= 1'b0;
         ack_ff          <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         half_counter_ff <= half_counter_in;
         bit_counter_ff  <= bit_counter_in;
         shift_ff        <= shift_in;
         scl_ff          <= scl_in;
         sda_ff          <= sda_in;
         stop_ff         <= stop_in;
         ack_ff          <= ack_in;
      end
   end

   assign result.scl_pull_low = scl_in;
   assign result.sda_pull_low = sda_in;
   assign result.ready_res    = (phase_in == i2cmw_pkg::PH_IDLE) ||
                                (phase_in == i2cmw_pkg::PH_WAIT_DATA);
   assign result.done_res     = done;
   assign result.acked_ok     = done & ok;

endmodule
